FILE: rtl/waveform_send_rate_generator_core_macros.svh
// assertion macros for the waveform send-rate generator core
// used by the top level; expects clk and rst in the enclosing module
`ifndef WAVEFORM_SEND_RATE_GENERATOR_CORE_MACROS_SVH
`define WAVEFORM_SEND_RATE_GENERATOR_CORE_MACROS_SVH

// same-cycle implication, skipped while reset is high
`define WSRG_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// implication checked in the following cycle
`define WSRG_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/wsrg_pkg.sv
// shared types and constants for the waveform send-rate generator
// no dependencies
package wsrg_pkg;

  localparam int COUNT_W    = 10;
  localparam int PHASE_W    = 16;
  localparam int AMP_W      = 16;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_ADDR_W = 3;

  // pi/2 in Q30 and the Taylor divisors 2n(2n+1) for n = 1..10
  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] TAYLOR_DIV [10] = '{
    64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272, 64'd342, 64'd420
  };
  localparam logic [AMP_W-1:0] HALF_SCALE = 16'h8000;

  // wave modes
  localparam logic [1:0] MODE_OFF    = 2'd0;
  localparam logic [1:0] MODE_SINE   = 2'd1;
  localparam logic [1:0] MODE_SQUARE = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_WAVE_MODE     = 3'd0,
    REG_MAX_PER_SLICE = 3'd1,
    REG_PHASE_STEP    = 3'd2,
    REG_SQUARE_PERIOD = 3'd3,
    REG_SQUARE_LOW    = 3'd4
  } cfg_reg_t;

  // how the back end forms the slice level
  typedef enum logic [1:0] {
    KIND_ZERO = 2'd0,
    KIND_SINE = 2'd1,
    KIND_PEAK = 2'd2
  } level_kind_t;

  typedef struct packed {
    logic [1:0]         wave_mode;
    logic [COUNT_W-1:0] max_per_slice;
    logic [PHASE_W-1:0] phase_step;
    logic [COUNT_W-1:0] square_period;
    logic [COUNT_W-1:0] square_low;
  } cfg_t;

  // one classified slot request
  typedef struct packed {
    logic               tick;
    logic               start;
    level_kind_t        kind;
    logic [AMP_W-1:0]   amp;
  } slot_req_t;

endpackage

FILE: rtl/wsrg_front.sv
// front end: accepts ticks, tracks slot, phase and square position, classifies
// each slot and looks up the sine amplitude; depends on wsrg_pkg
module wsrg_front #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic               clk,
  input  logic               rst,
  input  wsrg_pkg::cfg_t     cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               tick,
  output logic               req_valid,
  input  logic               req_ready,
  output wsrg_pkg::slot_req_t req
);
  import wsrg_pkg::*;

  localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int FRAC_W = PHASE_W - 2;
  localparam int PROD_W = FRAC_W + ADDR_W;

  typedef logic [AMP_W-1:0] sine_tab_t [SINE_TABLE_DEPTH + 1];

  // quarter-wave Q1.15 table, Taylor series in Q30 evaluated at elaboration
  function automatic sine_tab_t build_sine_tab();
    sine_tab_t          tab;
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic [63:0]        q;
    logic signed [63:0] sum;
    for (int k = 0; k <= SINE_TABLE_DEPTH; k++) begin
      x    = (64'(k) * HALF_PI_Q30) / SINE_TABLE_DEPTH;
      x2   = (x * x) >> 30;
      term = x;
      sum  = $signed(x);
      for (int n = 1; n <= 10; n++) begin
        term = ((term * x2) >> 30) / TAYLOR_DIV[n-1];
        if (n % 2 == 1) begin
          sum = sum - $signed(term);
        end else begin
          sum = sum + $signed(term);
        end
      end
      if (sum < 0) begin
        sum = 64'sd0;
      end
      q = ($unsigned(sum) * 64'd32767 + (64'd1 << 29)) >> 30;
      if (q > 64'd32767) begin
        q = 64'd32767;
      end
      tab[k] = q[AMP_W-1:0];
    end
    return tab;
  endfunction

  localparam sine_tab_t SINE_TAB = build_sine_tab();

  logic [COUNT_W-1:0] slot_index;
  logic [COUNT_W-1:0] slot_index_next;
  logic [PHASE_W-1:0] sine_phase;
  logic [COUNT_W-1:0] square_index;
  logic [COUNT_W-1:0] square_pos;
  logic [COUNT_W-1:0] period;
  logic               start;
  logic               take;
  logic [1:0]         quad;
  logic [PROD_W-1:0]  idx_prod;
  logic [ADDR_W-1:0]  idx;
  logic [ADDR_W-1:0]  addr;
  logic [AMP_W-1:0]   tab_val;
  logic [AMP_W-1:0]   amp;
  level_kind_t        kind;

  assign in_ready  = req_ready;
  assign req_valid = in_valid;
  assign take      = in_valid && req_ready && tick;
  assign start     = (slot_index == '0);

  // square position wraps before use; period zero acts as one
  assign period     = (cfg.square_period == '0) ? COUNT_W'(1) : cfg.square_period;
  assign square_pos = (square_index >= period) ? '0 : square_index;

  // sine amplitude lookup: quadrant fold of the table
  assign quad     = sine_phase[PHASE_W-1:PHASE_W-2];
  assign idx_prod = PROD_W'(sine_phase[FRAC_W-1:0]) * PROD_W'(SINE_TABLE_DEPTH);
  always_comb begin
    idx = idx_prod[PROD_W-1:FRAC_W];
    if (idx >= ADDR_W'(SINE_TABLE_DEPTH)) begin
      idx = ADDR_W'(SINE_TABLE_DEPTH - 1);
    end
  end
  assign addr    = quad[0] ? (ADDR_W'(SINE_TABLE_DEPTH) - idx) : idx;
  assign tab_val = SINE_TAB[addr];
  assign amp     = quad[1] ? (HALF_SCALE - tab_val) : (HALF_SCALE + tab_val);

  // level kind for this slice
  always_comb begin
    case (cfg.wave_mode)
      MODE_SINE:   kind = KIND_SINE;
      MODE_SQUARE: kind = (square_pos < cfg.square_low) ? KIND_ZERO : KIND_PEAK;
      default:     kind = KIND_ZERO;
    endcase
  end

  assign req.tick  = tick;
  assign req.start = tick && start;
  assign req.kind  = kind;
  assign req.amp   = amp;

  // slot counter wraps at the slice length
  always_comb begin
    slot_index_next = slot_index + COUNT_W'(1);
    if (slot_index_next >= cfg.max_per_slice) begin
      slot_index_next = '0;
    end
  end

  // slot state advances on accepted ticks; phase and square state on those that start a slice
  always_ff @(posedge clk) begin
    if (rst) begin
      slot_index   <= '0;
      sine_phase   <= '0;
      square_index <= '0;
    end else if (take) begin
      slot_index <= slot_index_next;
      if (start) begin
        sine_phase   <= sine_phase + cfg.phase_step;
        square_index <= square_pos + COUNT_W'(1);
      end
    end
  end

endmodule

FILE: rtl/wsrg_queue.sv
// two-entry request queue between the front and back ends
// depends on wsrg_pkg
module wsrg_queue (
  input  logic                clk,
  input  logic                rst,
  input  logic                push_valid,
  output logic                push_ready,
  input  wsrg_pkg::slot_req_t push_req,
  output logic                pop_valid,
  input  logic                pop_ready,
  output wsrg_pkg::slot_req_t pop_req
);
  import wsrg_pkg::*;

  slot_req_t  entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_req    = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_req;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

FILE: rtl/wsrg_back.sv
// back end: forms the slice level, spends credits and holds the result register
// depends on wsrg_pkg
module wsrg_back (
  input  logic                         clk,
  input  logic                         rst,
  input  logic [wsrg_pkg::COUNT_W-1:0] max_per_slice,
  input  logic                         req_valid,
  output logic                         req_ready,
  input  wsrg_pkg::slot_req_t          req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic                         send,
  output logic                         slice_start,
  output logic [wsrg_pkg::COUNT_W-1:0] slice_level
);
  import wsrg_pkg::*;

  localparam int MUL_W = COUNT_W + AMP_W;

  logic [COUNT_W-1:0] current_level;
  logic [COUNT_W-1:0] current_level_next;
  logic [COUNT_W-1:0] credits_left;
  logic [COUNT_W-1:0] credits_left_next;
  logic [MUL_W-1:0]   sine_prod;
  logic [COUNT_W-1:0] level;
  logic [COUNT_W-1:0] credit;
  logic               send_next;
  logic               pop;

  assign req_ready = !out_valid || out_ready;
  assign pop       = req_valid && req_ready;

  // sine level = max * (0.5 + sin/2), scaled by the Q16 amplitude; peak level is max, else zero
  assign sine_prod = MUL_W'(max_per_slice) * MUL_W'(req.amp);
  always_comb begin
    case (req.kind)
      KIND_SINE: level = sine_prod[MUL_W-1:AMP_W];
      KIND_PEAK: level = max_per_slice;
      default:   level = '0;
    endcase
  end

  // credit spend for this slot
  always_comb begin
    current_level_next = current_level;
    credits_left_next  = credits_left;
    send_next          = 1'b0;
    if (req.tick) begin
      credit = req.start ? level : credits_left;
      if (req.start) begin
        current_level_next = level;
      end
      send_next         = (credit != '0);
      credits_left_next = credit - COUNT_W'(send_next);
    end else begin
      credit = credits_left;
    end
  end

  // slice state
  always_ff @(posedge clk) begin
    if (rst) begin
      current_level <= '0;
      credits_left  <= '0;
    end else if (pop) begin
      current_level <= current_level_next;
      credits_left  <= credits_left_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      send        <= send_next;
      slice_start <= req.start;
      slice_level <= current_level_next;
    end
  end

endmodule

FILE: rtl/waveform_send_rate_generator_core.sv
// Waveform send-rate generator, top level.
// Input channel: in_valid/in_ready with one field, tick; one request per
// send interval. tick low is an idle slot that changes no state.
// Output channel: out_valid/out_ready with send, slice_start, slice_level;
// exactly one result for each accepted request, in order.
// Configuration: cfg_wr_en writes cfg_wdata into the register at cfg_addr
// (0 wave_mode, 1 max_per_slice, 2 phase_step, 3 square_period,
// 4 square_low); other addresses are ignored. Write only while idle.
// An accepted request is written into the queue; after the back end pops it,
// its result is written into the output register and presented there.
// Throughput: one request per cycle when not stalled; the sine table read sits
// in the front end and the level multiply plus credit update in the back end.
// When the receiver stalls, the output register holds and the two-entry
// queue absorbs up to two more requests before in_ready drops.
// Reset: configuration returns to its defaults, all counters, phase and
// credits clear, the queue empties; no clearing pass is needed.
// Depends on wsrg_pkg, wsrg_front, wsrg_queue, wsrg_back and the macro header.
`include "waveform_send_rate_generator_core_macros.svh"

module waveform_send_rate_generator_core #(
  parameter int SINE_TABLE_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            cfg_wr_en,
  input  logic [wsrg_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [wsrg_pkg::CFG_DATA_W-1:0] cfg_wdata,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic                            tick,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic                            send,
  output logic                            slice_start,
  output logic [wsrg_pkg::COUNT_W-1:0]    slice_level
);
  import wsrg_pkg::*;

  cfg_t      cfg;
  slot_req_t front_req;
  slot_req_t back_req;
  logic      front_valid;
  logic      front_ready;
  logic      back_valid;
  logic      back_ready;
  logic      off_mode;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.wave_mode     <= MODE_OFF;
      cfg.max_per_slice <= COUNT_W'(16);
      cfg.phase_step    <= PHASE_W'(1043);
      cfg.square_period <= COUNT_W'(50);
      cfg.square_low    <= COUNT_W'(25);
    end else if (cfg_wr_en) begin
      case (cfg_reg_t'(cfg_addr))
        REG_WAVE_MODE:     cfg.wave_mode     <= cfg_wdata[1:0];
        REG_MAX_PER_SLICE: cfg.max_per_slice <= cfg_wdata[COUNT_W-1:0];
        REG_PHASE_STEP:    cfg.phase_step    <= cfg_wdata[PHASE_W-1:0];
        REG_SQUARE_PERIOD: cfg.square_period <= cfg_wdata[COUNT_W-1:0];
        REG_SQUARE_LOW:    cfg.square_low    <= cfg_wdata[COUNT_W-1:0];
        default: ;
      endcase
    end
  end

  // front end
  wsrg_front #(
    .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .tick      (tick),
    .req_valid (front_valid),
    .req_ready (front_ready),
    .req       (front_req)
  );

  // decoupling queue
  wsrg_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .push_req   (front_req),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready),
    .pop_req    (back_req)
  );

  // back end
  wsrg_back u_back (
    .clk           (clk),
    .rst           (rst),
    .max_per_slice (cfg.max_per_slice),
    .req_valid     (back_valid),
    .req_ready     (back_ready),
    .req           (back_req),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .send          (send),
    .slice_start   (slice_start),
    .slice_level   (slice_level)
  );

  // mode codes that produce no sends
  assign off_mode = (cfg.wave_mode == MODE_OFF) || (cfg.wave_mode == MODE_UNUSED);

  // a send needs a nonzero slice level
  `WSRG_ASSERT_IMPL(a_send_needs_level, out_valid && send, slice_level != '0, "send with zero level")
  // a new slice never exceeds the peak count
  `WSRG_ASSERT_IMPL(a_level_bound, out_valid && slice_start, slice_level <= cfg.max_per_slice, "level above max")
  // off mode starts every slice at zero
  `WSRG_ASSERT_IMPL(a_off_zero, out_valid && slice_start && off_mode, slice_level == '0, "nonzero level while off")
  // a request handed to the back end shows up at the output next cycle
  `WSRG_ASSERT_NEXT(a_pop_to_out, back_valid && back_ready, out_valid, "popped request not presented")

endmodule
